@@ rtl/bpc_pkg.sv @@
// Package: constants, types and helpers of the button press classifier.
`timescale 1ns / 1ps
package bpc_pkg;

   localparam int NUM_BUTTONS       = 6;
   localparam int LEVEL_WIDTH       = 6;
   localparam int BUTTON_IDX_WIDTH  = 3;
   localparam int TICK_WIDTH        = 16;
   localparam int SHIFT_COUNT_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 16;
   localparam int REQ_TDATA_WIDTH   = 8;
   localparam int RSP_TDATA_WIDTH   = 16;

   localparam logic [SHIFT_COUNT_WIDTH-1:0] SHIFT_COUNT_MAX = 8'd255;
   localparam logic [TICK_WIDTH-1:0]        TICK_MAX        = '1;

   localparam logic [TICK_WIDTH-1:0]       LONG_THRESHOLD_RESET = 16'd2000;
   localparam logic [TICK_WIDTH-1:0]       WAKE_THRESHOLD_RESET = 16'd1500;
   localparam logic [LEVEL_WIDTH-1:0]      WAKE_LATCH_RESET     = '0;
   localparam logic [BUTTON_IDX_WIDTH-1:0] SHIFT_BUTTON_RESET   = 3'd5;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LONG_THRESHOLD = 2'd0,
      CSR_WAKE_THRESHOLD = 2'd1,
      CSR_WAKE_LATCH     = 2'd2,
      CSR_SHIFT_BUTTON   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                        found;
      logic [BUTTON_IDX_WIDTH-1:0] index;
   } pick_type;

   // Lowest pressed button among the first NUM_BUTTONS bits.
   function automatic pick_type lowest_button(input logic [LEVEL_WIDTH-1:0] bits);
      pick_type result;
      result.found = 1'b0;
      result.index = '0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            result.found = 1'b1;
            result.index = BUTTON_IDX_WIDTH'(i);
         end
      end
      return result;
   endfunction

endpackage

@@ rtl/button_press_classifier_core.sv @@
// Top level: long/short press classifier for a bank of six buttons, one tick per item.
`timescale 1ns / 1ps
// One input item is one timer tick carrying the sampled button levels. While idle the
// block latches the lowest pressed button and counts ticks while it stays held; it
// emits one event item when the button is released (short press) or when the hold
// reaches its threshold (long press, also when both happen on the same tick). On the
// first tick after reset a button set in the wake latch is taken instead, measured
// against the wake threshold. Each event reports how many short presses of the shift
// button came directly before it; the count saturates at 255 and clears on any other
// event. Every item is classified in the cycle it is accepted and its event, if any,
// sits in a single output register; a new item is taken every cycle as long as that
// register is empty or being drained, so throughput is one item per clock. Configuration
// writes take effect at the next edge; the user must make them only while no item is in
// flight, and the block itself does not enforce this.
module button_press_classifier_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // tick items
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bpc_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,   // [5:0] button_levels
   // event items
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bpc_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,   // [2:0] button_index,
                                                              // [10:3] shift_presses
   output logic                                  rsp_tuser,   // [0] long_press
   // register writes
   input  logic                                  csr_we,
   input  logic [bpc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bpc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import bpc_pkg::*;

   // configuration registers
   logic [TICK_WIDTH-1:0]       long_threshold_ff;
   logic [TICK_WIDTH-1:0]       wake_threshold_ff;
   logic [LEVEL_WIDTH-1:0]      wake_latch_ff;
   logic [BUTTON_IDX_WIDTH-1:0] shift_button_ff;

   // classifier state
   logic                         started_ff, started_in;
   logic                         holding_ff, holding_in;
   logic [BUTTON_IDX_WIDTH-1:0]  held_button_ff, held_button_in;
   logic [TICK_WIDTH-1:0]        hold_ticks_ff, hold_ticks_in;
   logic [TICK_WIDTH-1:0]        threshold_ff, threshold_in;
   logic [SHIFT_COUNT_WIDTH-1:0] shift_count_ff, shift_count_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [BUTTON_IDX_WIDTH-1:0]  rsp_button_ff, rsp_button_in;
   logic                         rsp_long_ff, rsp_long_in;
   logic [SHIFT_COUNT_WIDTH-1:0] rsp_shift_ff, rsp_shift_in;

   logic                   req_accept;
   logic [LEVEL_WIDTH-1:0] levels;
   pick_type               wake_pick;
   pick_type               level_pick;
   logic [TICK_WIDTH-1:0]  ticks_inc;
   logic                   is_long;
   logic                   pressed;
   logic                   emit;

   // Take a new tick whenever the output register is empty or drains this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign levels     = req_tdata[LEVEL_WIDTH-1:0];
   assign wake_pick  = lowest_button(wake_latch_ff);
   assign level_pick = lowest_button(levels);

   // Hold counter saturates at its full range.
   assign ticks_inc = (hold_ticks_ff == TICK_MAX) ? hold_ticks_ff : hold_ticks_ff + 1'b1;
   assign is_long   = ticks_inc >= threshold_ff;
   assign pressed   = levels[held_button_ff];

   always_comb begin
      started_in     = started_ff;
      holding_in     = holding_ff;
      held_button_in = held_button_ff;
      hold_ticks_in  = hold_ticks_ff;
      threshold_in   = threshold_ff;
      shift_count_in = shift_count_ff;
      emit           = 1'b0;

      if (!started_ff && wake_pick.found) begin
         // first tick after reset: adopt the wake-latched button
         started_in     = 1'b1;
         holding_in     = 1'b1;
         held_button_in = wake_pick.index;
         hold_ticks_in  = '0;
         threshold_in   = wake_threshold_ff;
      end else if (!holding_ff) begin
         started_in = 1'b1;
         if (level_pick.found) begin
            holding_in     = 1'b1;
            held_button_in = level_pick.index;
            hold_ticks_in  = '0;
            threshold_in   = long_threshold_ff;
         end
      end else begin
         started_in = 1'b1;
         if (pressed && !is_long) begin
            hold_ticks_in = ticks_inc;
         end else begin
            // release or threshold reached: close the press and emit
            emit          = 1'b1;
            holding_in    = 1'b0;
            hold_ticks_in = '0;
            if (held_button_ff == shift_button_ff && !is_long) begin
               if (shift_count_ff < SHIFT_COUNT_MAX) begin
                  shift_count_in = shift_count_ff + 1'b1;
               end
            end else begin
               shift_count_in = '0;
            end
         end
      end
   end

   // Load the output register on an accepted tick, drop the event once taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_button_in = rsp_button_ff;
      rsp_long_in   = rsp_long_ff;
      rsp_shift_in  = rsp_shift_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && emit) begin
         rsp_valid_in  = 1'b1;
         rsp_button_in = held_button_ff;
         rsp_long_in   = is_long;
         rsp_shift_in  = shift_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_threshold_ff <= LONG_THRESHOLD_RESET;
         wake_threshold_ff <= WAKE_THRESHOLD_RESET;
         wake_latch_ff     <= WAKE_LATCH_RESET;
         shift_button_ff   <= SHIFT_BUTTON_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LONG_THRESHOLD: long_threshold_ff <= csr_wdata[TICK_WIDTH-1:0];
            CSR_WAKE_THRESHOLD: wake_threshold_ff <= csr_wdata[TICK_WIDTH-1:0];
            CSR_WAKE_LATCH:     wake_latch_ff     <= csr_wdata[LEVEL_WIDTH-1:0];
            CSR_SHIFT_BUTTON:   shift_button_ff   <= csr_wdata[BUTTON_IDX_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         holding_ff     <= 1'b0;
         held_button_ff <= '0;
         hold_ticks_ff  <= '0;
         threshold_ff   <= '0;
         shift_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            started_ff     <= started_in;
            holding_ff     <= holding_in;
            held_button_ff <= held_button_in;
            hold_ticks_ff  <= hold_ticks_in;
            threshold_ff   <= threshold_in;
            shift_count_ff <= shift_count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_button_ff <= rsp_button_in;
      rsp_long_ff   <= rsp_long_in;
      rsp_shift_ff  <= rsp_shift_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_WIDTH - SHIFT_COUNT_WIDTH - BUTTON_IDX_WIDTH){1'b0}},
                        rsp_shift_ff, rsp_button_ff};
   assign rsp_tuser  = rsp_long_ff;

endmodule
